FILE: src/rtc_cmos_pkg.sv
package rtc_cmos_pkg;

  localparam int STORE_DEPTH_DEF = 96;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_HIGH = 1'd1;

  localparam logic [1:0] FUNC_BUS  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_TOD  = 2'd2;

  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  localparam logic [6:0] R_SEC    = 7'h00;
  localparam logic [6:0] R_MIN    = 7'h02;
  localparam logic [6:0] R_HOUR   = 7'h04;
  localparam logic [6:0] R_DOW    = 7'h06;
  localparam logic [6:0] R_DOM    = 7'h07;
  localparam logic [6:0] R_MON    = 7'h08;
  localparam logic [6:0] R_YEAR   = 7'h09;
  localparam logic [6:0] R_A      = 7'h0A;
  localparam logic [6:0] R_B      = 7'h0B;
  localparam logic [6:0] R_C      = 7'h0C;
  localparam logic [6:0] R_D      = 7'h0D;
  localparam logic [6:0] NV_FIRST = 7'h0E;
  localparam logic [6:0] NV_LAST  = 7'h40;
  localparam logic [6:0] R_CENT   = 7'h32;
  localparam logic [6:0] R_MLO0   = 7'h34;
  localparam logic [6:0] R_MLO1   = 7'h35;
  localparam logic [6:0] R_MHI0   = 7'h5B;
  localparam logic [6:0] R_MHI1   = 7'h5C;
  localparam logic [6:0] R_MHI2   = 7'h5D;

  localparam int NUM_FLOP_REGS = 14;

  localparam int BIT_PF  = 6;
  localparam int BIT_PIE = 6;
  localparam int BIT_VRT = 7;

  localparam logic [7:0] B_RESET = 8'h02;
  localparam logic [7:0] D_RESET = 8'h80;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  func;
    logic        port_sel;
    logic        is_read;
    logic [7:0]  write_data;
    logic [5:0]  tod_second;
    logic [5:0]  tod_minute;
    logic [4:0]  tod_hour;
    logic [2:0]  tod_weekday;
    logic [4:0]  tod_day;
    logic [3:0]  tod_month;
    logic [13:0] tod_year;
  } rtc_item_t;

  typedef struct packed {
    logic exec;
    logic fetch_done;
    logic year_done;
  } rtc_cmd_t;

  typedef struct packed {
    logic needs_fetch;
    logic needs_year;
    logic out_busy;
  } rtc_stat_t;

  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] tens7;
    logic [6:0] tens10;
    logic [6:0] ones;
    tens = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(10 * i)) begin
        tens = 4'(i);
      end
    end
    tens7  = {3'b000, tens};
    tens10 = 7'((tens7 << 3) + (tens7 << 1));
    ones   = v - tens10;
    return {tens, ones[3:0]};
  endfunction

endpackage

FILE: src/rtc_cmos_in_if.sv
interface rtc_cmos_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        port_sel;
  logic        is_read;
  logic [7:0]  write_data;
  logic [5:0]  tod_second;
  logic [5:0]  tod_minute;
  logic [4:0]  tod_hour;
  logic [2:0]  tod_weekday;
  logic [4:0]  tod_day;
  logic [3:0]  tod_month;
  logic [13:0] tod_year;

  modport source (
    output valid, func, port_sel, is_read, write_data, tod_second, tod_minute,
           tod_hour, tod_weekday, tod_day, tod_month, tod_year,
    input  ready
  );

  modport sink (
    input  valid, func, port_sel, is_read, write_data, tod_second, tod_minute,
           tod_hour, tod_weekday, tod_day, tod_month, tod_year,
    output ready
  );
endinterface

FILE: src/rtc_cmos_out_if.sv
interface rtc_cmos_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       periodic_irq;
  logic       write_ignored;

  modport source (
    output valid, read_data, periodic_irq, write_ignored,
    input  ready
  );

  modport sink (
    input  valid, read_data, periodic_irq, write_ignored,
    output ready
  );
endinterface

FILE: src/rtc_cmos_ctrl.sv
module rtc_cmos_ctrl import rtc_cmos_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rtc_stat_t stat,
  output rtc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_YEAR  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready       = (state_r == ST_IDLE) && !stat.out_busy;
  assign cmd.exec       = in_valid && in_ready;
  assign cmd.fetch_done = (state_r == ST_FETCH);
  assign cmd.year_done  = (state_r == ST_YEAR);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.exec && stat.needs_fetch) begin
          state_nxt = ST_FETCH;
        end else if (cmd.exec && stat.needs_year) begin
          state_nxt = ST_YEAR;
        end
      end
      ST_FETCH: state_nxt = ST_IDLE;
      ST_YEAR:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/rtc_cmos_dp.sv
module rtc_cmos_dp import rtc_cmos_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtc_item_t             item,
  input  rtc_cmd_t              cmd,
  output rtc_stat_t             stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            read_data,
  output logic                  periodic_irq,
  output logic                  write_ignored
);

  localparam int IDX_W = $clog2(STORE_DEPTH);

  logic [7:0]  regs_r [NUM_FLOP_REGS];
  logic [7:0]  cent_r;
  logic [7:0]  mlo0_r;
  logic [7:0]  mlo1_r;
  logic [7:0]  mhi0_r;
  logic [7:0]  mhi1_r;
  logic [7:0]  mhi2_r;
  logic [6:0]  index_r;
  logic [13:0] count_r;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [7:0]             memq_r;
  logic                   memv_r;

  logic [13:0] year_r;
  logic [6:0]  cq_r;

  logic       out_valid_r;
  logic [7:0] rdata_r;
  logic       irq_r;
  logic       ign_r;

  logic [6:0]       idx;
  logic [IDX_W-1:0] maddr;
  logic             is_bus;
  logic             is_tick;
  logic             is_tod;
  logic             data_wr;
  logic             data_rd;
  logic             in_nv;
  logic             in_mem;
  logic [7:0]       direct_rd;
  logic [7:0]       exec_rdata;
  logic             exec_ign;
  logic [3:0]       rs;
  logic [14:0]      period;
  logic [14:0]      cnt_inc;
  logic             fire;
  logic [13:0]      year_sat;
  logic [26:0]      year_prod;
  logic [13:0]      cq14;
  logic [13:0]      year_rem;
  logic [6:0]       idx_clamp;

  assign idx     = index_r;
  assign maddr   = idx[IDX_W-1:0];
  assign is_bus  = (item.func == FUNC_BUS);
  assign is_tick = (item.func == FUNC_TICK);
  assign is_tod  = (item.func == FUNC_TOD);
  assign data_wr = is_bus && (item.port_sel == PORT_DATA) && !item.is_read;
  assign data_rd = is_bus && (item.port_sel == PORT_DATA) && item.is_read;
  assign in_nv   = (idx >= NV_FIRST) && (idx <= NV_LAST);
  assign in_mem  = in_nv && (idx != R_CENT) && (idx != R_MLO0) && (idx != R_MLO1);

  assign stat.needs_fetch = data_rd && in_mem;
  assign stat.needs_year  = is_tod;
  assign stat.out_busy    = out_valid_r && !out_ready;

  always_comb begin
    direct_rd = 8'h00;
    if (idx <= R_D) begin
      direct_rd = regs_r[idx[3:0]];
    end else begin
      case (idx)
        R_CENT:  direct_rd = cent_r;
        R_MLO0:  direct_rd = mlo0_r;
        R_MLO1:  direct_rd = mlo1_r;
        R_MHI0:  direct_rd = mhi0_r;
        R_MHI1:  direct_rd = mhi1_r;
        R_MHI2:  direct_rd = mhi2_r;
        default: direct_rd = 8'h00;
      endcase
    end
  end

  always_comb begin
    exec_rdata = 8'h00;
    if (is_bus && item.is_read) begin
      if (item.port_sel == PORT_INDEX) begin
        exec_rdata = {1'b0, index_r};
      end else begin
        exec_rdata = direct_rd;
      end
    end
  end

  assign exec_ign = data_wr && (idx > R_YEAR) && !in_nv && (idx != R_A) && (idx != R_B);

  assign rs      = regs_r[R_A[3:0]][3:0];
  assign period  = 15'd1 << (rs - 4'd1);
  assign cnt_inc = {1'b0, count_r} + 15'd1;
  assign fire    = (rs != 4'd0) && (cnt_inc >= period);

  assign year_sat  = (item.tod_year > YEAR_MAX) ? YEAR_MAX : item.tod_year;
  assign year_prod = 27'(year_sat) * 27'(RECIP_100);
  assign cq14      = {7'b0000000, cq_r};
  assign year_rem  = year_r - 14'((cq14 << 6) + (cq14 << 5) + (cq14 << 2));

  assign idx_clamp = ({1'b0, item.write_data[6:0]} < 8'(STORE_DEPTH))
                     ? item.write_data[6:0] : R_D;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FLOP_REGS; i++) begin
        if (i == int'(R_B)) begin
          regs_r[i] <= B_RESET;
        end else if (i == int'(R_D)) begin
          regs_r[i] <= D_RESET;
        end else begin
          regs_r[i] <= 8'h00;
        end
      end
      cent_r      <= 8'h00;
      mlo0_r      <= 8'h00;
      mlo1_r      <= 8'h00;
      mhi0_r      <= 8'h00;
      mhi1_r      <= 8'h00;
      mhi2_r      <= 8'h00;
      index_r     <= 7'd0;
      count_r     <= 14'd0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEM_LOW: begin
            mlo0_r <= cfg_data[7:0];
            mlo1_r <= cfg_data[15:8];
          end
          CFG_MEM_HIGH: begin
            mhi0_r <= cfg_data[7:0];
            mhi1_r <= cfg_data[15:8];
            mhi2_r <= cfg_data[23:16];
          end
          default: begin
          end
        endcase
      end

      if (cmd.exec) begin
        if (is_bus) begin
          if (item.port_sel == PORT_INDEX) begin
            if (!item.is_read) begin
              index_r <= idx_clamp;
            end
          end else if (item.is_read) begin
            if (idx == R_C) begin
              regs_r[R_C[3:0]][BIT_PF] <= 1'b0;
            end
          end else if (idx <= R_YEAR) begin
            regs_r[idx[3:0]] <= item.write_data;
          end else if (in_nv) begin
            if (idx == R_CENT) begin
              cent_r <= item.write_data;
            end else if (idx == R_MLO0) begin
              mlo0_r <= item.write_data;
            end else if (idx == R_MLO1) begin
              mlo1_r <= item.write_data;
            end else begin
              vld_r[maddr] <= 1'b1;
            end
          end else if (idx == R_A) begin
            if ((regs_r[R_A[3:0]][3:0] ^ item.write_data[3:0]) != 4'd0) begin
              count_r <= 14'd0;
            end
            regs_r[R_A[3:0]] <= item.write_data;
          end else if (idx == R_B) begin
            regs_r[R_B[3:0]] <= item.write_data;
            if (item.write_data[BIT_PIE]) begin
              count_r <= 14'd0;
            end
          end
        end else if (is_tick) begin
          if (fire) begin
            count_r <= 14'd0;
            regs_r[R_C[3:0]][BIT_PF] <= 1'b1;
          end else if (rs != 4'd0) begin
            count_r <= cnt_inc[13:0];
          end
        end else if (is_tod) begin
          regs_r[R_SEC[3:0]]  <= bcd2({1'b0, item.tod_second});
          regs_r[R_MIN[3:0]]  <= bcd2({1'b0, item.tod_minute});
          regs_r[R_HOUR[3:0]] <= bcd2({2'b00, item.tod_hour});
          regs_r[R_DOW[3:0]]  <= bcd2(7'({4'b0000, item.tod_weekday} + 7'd1));
          regs_r[R_DOM[3:0]]  <= bcd2({2'b00, item.tod_day});
          regs_r[R_MON[3:0]]  <= bcd2(7'({3'b000, item.tod_month} + 7'd1));
          regs_r[R_D[3:0]][BIT_VRT] <= 1'b1;
        end
      end

      if (cmd.year_done) begin
        regs_r[R_YEAR[3:0]] <= bcd2(year_rem[6:0]);
        cent_r              <= bcd2(cq_r);
      end

      if ((cmd.exec && !stat.needs_fetch) || cmd.fetch_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && data_wr && in_mem) begin
      mem[maddr] <= item.write_data;
    end
    memq_r <= mem[maddr];
    memv_r <= vld_r[maddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && is_tod) begin
      year_r <= year_sat;
      cq_r   <= year_prod[RECIP_SHIFT+6:RECIP_SHIFT];
    end
    if (cmd.exec && !stat.needs_fetch) begin
      rdata_r <= exec_rdata;
      irq_r   <= is_tick && fire && regs_r[R_B[3:0]][BIT_PIE];
      ign_r   <= exec_ign;
    end else if (cmd.fetch_done) begin
      rdata_r <= memv_r ? memq_r : 8'h00;
      irq_r   <= 1'b0;
      ign_r   <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign read_data     = rdata_r;
  assign periodic_irq  = irq_r;
  assign write_ignored = ign_r;

endmodule

FILE: src/rtc_cmos_register_device.sv
// Index/data port real-time clock with a register store of STORE_DEPTH bytes in the
// usual layout: time bytes, control registers A to D, then NVRAM. Each input item is a
// bus access, a base tick or a time-of-day load, and gives exactly one result. A
// data-port read of an NVRAM byte passes a fetch state, since the NVRAM read port is
// registered, and a time-of-day load passes a year state that splits the year into
// year and century bytes by a registered reciprocal multiply; no new item is taken in
// either state. Results sit in an output register, and a new item is taken once that
// register is empty or being emptied in the same cycle. NVRAM bytes carry a valid bit
// each, cleared at reset, so there is no clearing pass and the block is ready as soon
// as reset is released. Configuration writes load the memory-size bytes directly.
module rtc_cmos_register_device import rtc_cmos_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rtc_cmos_in_if.sink           in_ch,
  rtc_cmos_out_if.source        out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rtc_item_t item;
  rtc_cmd_t  cmd;
  rtc_stat_t stat;

  assign item.func        = in_ch.func;
  assign item.port_sel    = in_ch.port_sel;
  assign item.is_read     = in_ch.is_read;
  assign item.write_data  = in_ch.write_data;
  assign item.tod_second  = in_ch.tod_second;
  assign item.tod_minute  = in_ch.tod_minute;
  assign item.tod_hour    = in_ch.tod_hour;
  assign item.tod_weekday = in_ch.tod_weekday;
  assign item.tod_day     = in_ch.tod_day;
  assign item.tod_month   = in_ch.tod_month;
  assign item.tod_year    = in_ch.tod_year;

  rtc_cmos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtc_cmos_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (item),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .read_data     (out_ch.read_data),
    .periodic_irq  (out_ch.periodic_irq),
    .write_ignored (out_ch.write_ignored)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rtc_cmos_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_CAP = 40;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic       periodic_irq;
    logic       write_ignored;
  } rtc_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rtc_cmos_in_if in_ch ();
  rtc_cmos_out_if out_ch ();

  rtc_item_t offered = '0;
  logic send_valid = 1'b0;
  logic recv_ready = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;

  rtc_item_t access_queue[$];
  rtc_reply_t expected_replies[$];
  int queued = 0;
  int accepted = 0;
  int replies_seen = 0;
  int error_count = 0;
  int cycles = 0;
  bit calm = 1'b0;

  logic [7:0]  cmos_bytes [DEPTH];
  logic [6:0]  sel_index;
  logic [13:0] tick_count;
  logic [15:0] mem_low;
  logic [23:0] mem_high;

  assign in_ch.valid       = send_valid;
  assign in_ch.func        = offered.func;
  assign in_ch.port_sel    = offered.port_sel;
  assign in_ch.is_read     = offered.is_read;
  assign in_ch.write_data  = offered.write_data;
  assign in_ch.tod_second  = offered.tod_second;
  assign in_ch.tod_minute  = offered.tod_minute;
  assign in_ch.tod_hour    = offered.tod_hour;
  assign in_ch.tod_weekday = offered.tod_weekday;
  assign in_ch.tod_day     = offered.tod_day;
  assign in_ch.tod_month   = offered.tod_month;
  assign in_ch.tod_year    = offered.tod_year;
  assign out_ch.ready      = recv_ready;

  rtc_cmos_register_device i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] to_bcd(input int unsigned v);
    int unsigned r;
    r = v % 100;
    return {4'(r / 10), 4'(r % 10)};
  endfunction

  function automatic void load_memory_size();
    cmos_bytes[R_MLO0] = mem_low[7:0];
    cmos_bytes[R_MLO1] = mem_low[15:8];
    cmos_bytes[R_MHI0] = mem_high[7:0];
    cmos_bytes[R_MHI1] = mem_high[15:8];
    cmos_bytes[R_MHI2] = mem_high[23:16];
  endfunction

  function automatic void reset_cmos();
    for (int i = 0; i < DEPTH; i++) begin
      cmos_bytes[i] = 8'h00;
    end
    cmos_bytes[R_B] = B_RESET;
    cmos_bytes[R_D] = D_RESET;
    sel_index = '0;
    tick_count = '0;
    mem_low = '0;
    mem_high = '0;
    load_memory_size();
  endfunction

  function automatic rtc_reply_t predict_access(input rtc_item_t it);
    rtc_reply_t res;
    int unsigned idx;
    int unsigned rate;
    int unsigned period;
    int unsigned nxt;
    int unsigned yr;
    logic [6:0] v;
    res = '0;
    idx = sel_index % DEPTH;
    case (it.func)
      FUNC_BUS: begin
        if (it.port_sel == PORT_INDEX) begin
          if (it.is_read) begin
            res.read_data = {1'b0, sel_index};
          end else begin
            v = it.write_data[6:0];
            sel_index = (v < DEPTH) ? v : R_D;
          end
        end else if (it.is_read) begin
          res.read_data = cmos_bytes[idx];
          if (idx == R_C) cmos_bytes[R_C][BIT_PF] = 1'b0;
        end else if (idx <= R_YEAR || (idx >= NV_FIRST && idx <= NV_LAST)) begin
          cmos_bytes[idx] = it.write_data;
        end else if (idx == R_A) begin
          if (cmos_bytes[R_A][3:0] != it.write_data[3:0]) tick_count = '0;
          cmos_bytes[R_A] = it.write_data;
        end else if (idx == R_B) begin
          cmos_bytes[R_B] = it.write_data;
          if (it.write_data[BIT_PIE]) tick_count = '0;
        end else begin
          res.write_ignored = 1'b1;
        end
      end
      FUNC_TICK: begin
        rate = cmos_bytes[R_A][3:0];
        if (rate != 0) begin
          period = 1 << (rate - 1);
          nxt = tick_count + 1;
          if (nxt >= period) begin
            tick_count = '0;
            cmos_bytes[R_C][BIT_PF] = 1'b1;
            if (cmos_bytes[R_B][BIT_PIE]) res.periodic_irq = 1'b1;
          end else begin
            tick_count = 14'(nxt);
          end
        end
      end
      FUNC_TOD: begin
        yr = (it.tod_year > YEAR_MAX) ? int'(YEAR_MAX) : int'(it.tod_year);
        cmos_bytes[R_SEC]  = to_bcd(it.tod_second);
        cmos_bytes[R_MIN]  = to_bcd(it.tod_minute);
        cmos_bytes[R_HOUR] = to_bcd(it.tod_hour);
        cmos_bytes[R_DOW]  = to_bcd(int'(it.tod_weekday) + 1);
        cmos_bytes[R_DOM]  = to_bcd(it.tod_day);
        cmos_bytes[R_MON]  = to_bcd(int'(it.tod_month) + 1);
        cmos_bytes[R_YEAR] = to_bcd(yr % 100);
        cmos_bytes[R_CENT] = to_bcd(yr / 100);
        cmos_bytes[R_D][BIT_VRT] = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("mismatch at reply %0d: %s got 0x%0h, expected 0x%0h",
               replies_seen, what, got, want);
    end
  endtask

  always @(posedge clk) begin : sender
    if (!rst_n) begin
      send_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (send_valid && in_ch.ready) begin
        expected_replies.push_back(predict_access(offered));
        accepted++;
      end
      if (send_valid && !in_ch.ready) begin
        // The offered item stays on the bus until its transfer.
      end else if (send_wait > 0) begin
        send_wait <= send_wait - 1;
        send_valid <= 1'b0;
      end else if (access_queue.size() > 0) begin
        offered <= access_queue.pop_front();
        send_valid <= 1'b1;
        send_wait <= pick_gap();
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    rtc_reply_t want;
    int unsigned g;
    if (!rst_n) begin
      recv_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      g = 0;
      if (out_ch.valid && recv_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply, read_data", out_ch.read_data, 0);
        end else begin
          want = expected_replies.pop_front();
          if (out_ch.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.read_data, want.read_data);
          if (out_ch.periodic_irq !== want.periodic_irq)
            report_mismatch("periodic_irq", out_ch.periodic_irq, want.periodic_irq);
          if (out_ch.write_ignored !== want.write_ignored)
            report_mismatch("write_ignored", out_ch.write_ignored, want.write_ignored);
        end
        replies_seen++;
        // Two long hold-offs let the block fill up and stall its input.
        if (replies_seen == 250 || replies_seen == 1000) g = HOLD_CYCLES;
        else g = pick_gap();
      end else if (recv_wait > 0) begin
        g = recv_wait - 1;
      end
      recv_wait <= g;
      recv_ready <= (g == 0);
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic rtc_item_t random_item();
    logic [63:0] raw;
    rtc_item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(rtc_item_t)-1:0];
    return it;
  endfunction

  task automatic queue_item(input rtc_item_t it);
    access_queue.push_back(it);
    queued++;
  endtask

  task automatic queue_bus(input logic port, input logic rd, input logic [7:0] wd);
    rtc_item_t it;
    it = random_item();
    it.func = FUNC_BUS;
    it.port_sel = port;
    it.is_read = rd;
    it.write_data = wd;
    queue_item(it);
  endtask

  task automatic queue_tick();
    rtc_item_t it;
    it = random_item();
    it.func = FUNC_TICK;
    queue_item(it);
  endtask

  task automatic queue_tod(input logic [5:0] sec, input logic [5:0] mins,
                           input logic [4:0] hr, input logic [2:0] wday,
                           input logic [4:0] day, input logic [3:0] mon,
                           input logic [13:0] yr);
    rtc_item_t it;
    it = random_item();
    it.func = FUNC_TOD;
    it.tod_second = sec;
    it.tod_minute = mins;
    it.tod_hour = hr;
    it.tod_weekday = wday;
    it.tod_day = day;
    it.tod_month = mon;
    it.tod_year = yr;
    queue_item(it);
  endtask

  task automatic select_reg(input logic [6:0] idx);
    queue_bus(PORT_INDEX, 1'b0, {1'($urandom), idx});
  endtask

  function automatic logic [6:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 7'($urandom_range(0, R_D));
    if (r < 50) begin
      case ($urandom_range(0, 5))
        0: return R_CENT;
        1: return R_MLO0;
        2: return R_MLO1;
        3: return R_MHI0;
        4: return R_MHI1;
        default: return R_MHI2;
      endcase
    end
    return 7'($urandom);
  endfunction

  task automatic queue_random_sequence();
    int unsigned r;
    int unsigned n;
    logic [3:0] rate;
    rtc_item_t it;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      select_reg(pick_index());
      n = $urandom_range(1, 3);
      repeat (n) queue_bus(PORT_DATA, 1'($urandom), 8'($urandom));
    end else if (r < 35) begin
      rate = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
      select_reg(R_A);
      queue_bus(PORT_DATA, 1'b0, {4'($urandom), rate});
    end else if (r < 43) begin
      select_reg(R_B);
      queue_bus(PORT_DATA, 1'b0, 8'($urandom));
    end else if (r < 63) begin
      n = $urandom_range(1, 24);
      repeat (n) queue_tick();
    end else if (r < 71) begin
      select_reg(R_C);
      queue_bus(PORT_DATA, 1'b1, 8'($urandom));
    end else if (r < 81) begin
      if ($urandom_range(0, 4) == 0) begin
        it = random_item();
        it.func = FUNC_TOD;
        queue_item(it);
      end else begin
        queue_tod(6'($urandom_range(0, 60)), 6'($urandom_range(0, 59)),
                  5'($urandom_range(0, 23)), 3'($urandom_range(0, 6)),
                  5'($urandom_range(1, 31)), 4'($urandom_range(0, 11)),
                  14'($urandom_range(0, 9999)));
      end
    end else if (r < 91) begin
      queue_bus(1'($urandom), 1'b1, 8'($urandom));
    end else begin
      it = random_item();
      queue_item(it);
    end
  endtask

  task automatic wait_idle();
    while (accepted != queued || expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MEM_LOW) mem_low = val[15:0];
    else mem_high = val;
    load_memory_size();
  endtask

  initial begin
    reset_cmos();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_cfg(CFG_MEM_LOW, '1);
    write_cfg(CFG_MEM_HIGH, '1);

    // Out-of-range index selects D, writes to C and D are refused, and the
    // periodic flag is set without the enable bit before the IRQ is enabled.
    queue_bus(PORT_INDEX, 1'b1, 8'h00);
    queue_bus(PORT_INDEX, 1'b0, 8'hFF);
    queue_bus(PORT_INDEX, 1'b1, 8'h00);
    queue_bus(PORT_DATA, 1'b1, 8'h00);
    queue_bus(PORT_DATA, 1'b0, 8'h55);
    queue_bus(PORT_INDEX, 1'b0, {1'b1, R_C});
    queue_bus(PORT_DATA, 1'b0, 8'hFF);
    queue_bus(PORT_INDEX, 1'b0, {1'b0, R_A});
    queue_bus(PORT_DATA, 1'b0, 8'h21);
    queue_tick();
    queue_bus(PORT_INDEX, 1'b0, {1'b0, R_C});
    queue_bus(PORT_DATA, 1'b1, 8'h00);
    queue_bus(PORT_DATA, 1'b1, 8'h00);
    queue_bus(PORT_INDEX, 1'b0, {1'b0, R_B});
    queue_bus(PORT_DATA, 1'b0, 8'h42);
    queue_tick();
    queue_bus(PORT_INDEX, 1'b0, 8'(DEPTH - 1));
    queue_bus(PORT_DATA, 1'b0, 8'h00);
    queue_bus(PORT_INDEX, 1'b0, {1'b0, NV_LAST});
    queue_bus(PORT_DATA, 1'b0, 8'hFF);
    queue_bus(PORT_DATA, 1'b1, 8'h00);
    queue_tod('1, '1, '1, '1, '1, '1, '1);
    queue_tod('0, '0, '0, '0, '0, '0, '0);
    queue_item('{func: FUNC_UNUSED, default: '1});
    queue_bus(PORT_INDEX, 1'b0, {1'b0, R_MLO1});
    queue_bus(PORT_DATA, 1'b1, 8'h00);

    for (int ph = 1; ph <= 5; ph++) begin
      wait_idle();
      repeat (4) @(posedge clk);
      if (ph == 1) begin
        write_cfg(CFG_MEM_LOW, '0);
        write_cfg(CFG_MEM_HIGH, '0);
      end else begin
        write_cfg(CFG_MEM_LOW, CFG_DATA_W'($urandom));
        write_cfg(CFG_MEM_HIGH, CFG_DATA_W'($urandom));
      end
      calm = (ph == 3);
      select_reg(R_MHI2);
      queue_bus(PORT_DATA, 1'b1, 8'h00);
      while (queued < 26 + ph * 260) queue_random_sequence();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
